// ===== hdl/ptts_pkg.sv =====
// Package for the periodic task tick scheduler.
// Holds command codes, controller states and the slot memory entry type.
// No dependencies.
package ptts_pkg;

    localparam int TASK_ID_W = 3;
    localparam int TIME_W    = 16;

    typedef enum logic [2:0] {
        KIND_TICK    = 3'd0,
        KIND_CREATE  = 3'd1,
        KIND_SUSPEND = 3'd2,
        KIND_RESUME  = 3'd3,
        KIND_DELETE  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] countdown;
    } slot_entry_t;

endpackage

// ===== hdl/ptts_if.sv =====
// Handshake channels of the tick scheduler: command in, due task out.
// Depends on ptts_pkg for field widths.
interface ptts_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     kind;
    logic [ptts_pkg::TASK_ID_W-1:0] task_id;
    logic [ptts_pkg::TIME_W-1:0]    period;
    logic [ptts_pkg::TIME_W-1:0]    first_delay;

    modport source (output valid, kind, task_id, period, first_delay, input ready);
    modport sink   (input valid, kind, task_id, period, first_delay, output ready);
endinterface

interface ptts_run_if;
    logic                           valid;
    logic                           ready;
    logic [ptts_pkg::TASK_ID_W-1:0] run_task;
    logic                           last;

    modport source (output valid, run_task, last, input ready);
    modport sink   (input valid, run_task, last, output ready);
endinterface

// ===== hdl/ptts_slot_ram.sv =====
// Slot memory: period and countdown per task, one write and one read port.
// Read data is registered. Depends on ptts_pkg.
module ptts_slot_ram #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  ptts_pkg::slot_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output ptts_pkg::slot_entry_t rd_data
);

    ptts_pkg::slot_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/periodic_task_tick_scheduler_top.sv =====
// Periodic task tick scheduler: command decode, tick scan and result staging.
// Depends on ptts_pkg, ptts_if and ptts_slot_ram.
// Create, suspend, resume and delete are applied in the idle state as they are accepted.
// A tick scans every slot and can be held by sink stalls; a due task leaves when the next
// one is found, the final one in the flush state after the scan.
// Reset clears all present and ready flags; the memory needs no clearing.
module periodic_task_tick_scheduler_top #(
    parameter int NUM_TASKS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    ptts_cmd_if.sink       cmd,
    ptts_run_if.source     run
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam int TW    = ptts_pkg::TIME_W;

    ptts_pkg::state_t state_reg, state_next;

    logic [NUM_TASKS-1:0] present_reg, present_next;
    logic [NUM_TASKS-1:0] ready_reg, ready_next;

    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0] s1_idx_reg, s1_idx_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic             out_last_reg, out_last_next;

    logic                  cmd_fire;
    logic                  id_ok;
    logic [IDX_W-1:0]      cmd_idx;
    logic                  create_fire;
    logic                  scan_done;
    logic                  out_free;
    logic                  hit;
    logic                  due;
    logic                  stall;
    logic                  s1_go;
    logic                  rd_en;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    ptts_pkg::slot_entry_t wr_data;
    ptts_pkg::slot_entry_t rd_data;

    ptts_slot_ram #(
        .DEPTH  (NUM_TASKS),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign cmd_fire    = cmd.valid && cmd.ready;
    assign id_ok       = (32'(cmd.task_id) < NUM_TASKS);
    assign cmd_idx     = IDX_W'(cmd.task_id);
    assign create_fire = cmd_fire && (cmd.kind == ptts_pkg::KIND_CREATE) && id_ok
                         && !present_reg[cmd_idx];

    assign scan_done = (rd_idx_reg == CNT_W'(NUM_TASKS)) && !s1_valid_reg;
    assign out_free  = !out_valid_reg || run.ready;
    assign hit       = present_reg[s1_idx_reg] && ready_reg[s1_idx_reg];
    assign due       = (rd_data.countdown == '0);
    // Hold the scan while a due slot would push the pending result into a full output.
    assign stall     = s1_valid_reg && hit && due && pend_valid_reg && !out_free;
    assign s1_go     = s1_valid_reg && !stall;
    assign rd_en     = (state_reg == ptts_pkg::ST_SCAN) && !stall
                       && (rd_idx_reg != CNT_W'(NUM_TASKS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptts_pkg::ST_IDLE:
            begin
                if (cmd_fire && (cmd.kind == ptts_pkg::KIND_TICK))
                begin
                    state_next = ptts_pkg::ST_SCAN;
                end
            end
            ptts_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ptts_pkg::ST_FLUSH;
                end
            end
            ptts_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ptts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptts_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        cmd.ready       = (state_reg == ptts_pkg::ST_IDLE);
        present_next    = present_reg;
        ready_next      = ready_reg;
        rd_idx_next     = rd_idx_reg;
        s1_valid_next   = s1_valid_reg;
        s1_idx_next     = s1_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !run.ready;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = s1_idx_reg;
        wr_data         = rd_data;

        case (state_reg)
            ptts_pkg::ST_IDLE:
            begin
                rd_idx_next   = '0;
                s1_valid_next = 1'b0;
                if (cmd_fire && id_ok)
                begin
                    case (cmd.kind)
                        ptts_pkg::KIND_CREATE:
                        begin
                            if (create_fire)
                            begin
                                present_next[cmd_idx] = 1'b1;
                                ready_next[cmd_idx]   = 1'b1;
                                wr_en                 = 1'b1;
                                wr_addr               = cmd_idx;
                                wr_data.period        = cmd.period;
                                wr_data.countdown     = cmd.first_delay;
                            end
                        end
                        ptts_pkg::KIND_SUSPEND: ready_next[cmd_idx]   = 1'b0;
                        ptts_pkg::KIND_RESUME:  ready_next[cmd_idx]   = 1'b1;
                        ptts_pkg::KIND_DELETE:  present_next[cmd_idx] = 1'b0;
                        default: ;
                    endcase
                end
            end
            ptts_pkg::ST_SCAN:
            begin
                if (!stall)
                begin
                    s1_valid_next = rd_en;
                    if (rd_en)
                    begin
                        s1_idx_next = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                end
                if (s1_go && hit)
                begin
                    wr_en = 1'b1;
                    if (due)
                    begin
                        // Reload and queue this slot; release the earlier one as not last.
                        wr_data.countdown = rd_data.period - TW'(1);
                        pend_valid_next   = 1'b1;
                        pend_idx_next     = s1_idx_reg;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_idx_next   = pend_idx_reg;
                            out_last_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        wr_data.countdown = rd_data.countdown - TW'(1);
                    end
                end
            end
            ptts_pkg::ST_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    pend_valid_next = 1'b0;
                    out_valid_next  = 1'b1;
                    out_idx_next    = pend_idx_reg;
                    out_last_next   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign run.valid    = out_valid_reg;
    assign run.run_task = ptts_pkg::TASK_ID_W'(out_idx_reg);
    assign run.last     = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptts_pkg::ST_IDLE;
            present_reg    <= '0;
            ready_reg      <= '0;
            rd_idx_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            present_reg    <= present_next;
            ready_reg      <= ready_next;
            rd_idx_reg     <= rd_idx_next;
            s1_valid_reg   <= s1_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= s1_idx_next;
        pend_idx_reg <= pend_idx_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== tb/sv/periodic_task_tick_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the periodic task tick scheduler top level.
// Depends on ptts_pkg, ptts_if and the scheduler RTL; models the slot table
// itself and checks every due-task transfer against it.
module periodic_task_tick_scheduler_top_tb;

    localparam int NUM_TASKS      = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4 * (NUM_TASKS + 2);
    localparam int REPORT_LIMIT   = 10;

    // Command codes the block must ignore.
    localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic [ptts_pkg::TASK_ID_W-1:0] slot;
        logic                           last;
    } due_task_t;

    logic clk = 1'b0;
    logic rst_n;

    ptts_cmd_if cmd_ch();
    ptts_run_if run_ch();

    periodic_task_tick_scheduler_top #(
        .NUM_TASKS (NUM_TASKS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .run   (run_ch)
    );

    // Slot table as the scheduler should hold it.
    logic                        slot_present   [NUM_TASKS];
    logic                        slot_ready     [NUM_TASKS];
    logic [ptts_pkg::TIME_W-1:0] slot_period    [NUM_TASKS];
    logic [ptts_pkg::TIME_W-1:0] slot_countdown [NUM_TASKS];

    due_task_t due_q[$];
    int        due_total;
    int        mismatch_count;
    int        src_idle_pct;
    int        sink_stall_pct;
    int        quiet_cycles;

    always #10 clk = ~clk;

    function automatic void flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $time, what);
        end
    endfunction

    // Advance the slot table by one command and queue the due tasks it raises.
    function automatic void apply_command(input logic [2:0] kind,
                                          input logic [ptts_pkg::TASK_ID_W-1:0] id,
                                          input logic [ptts_pkg::TIME_W-1:0] per,
                                          input logic [ptts_pkg::TIME_W-1:0] fd);
        logic [ptts_pkg::TASK_ID_W-1:0] fired[$];
        due_task_t                      entry;
        if (kind == ptts_pkg::KIND_TICK)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                if (slot_present[i] && slot_ready[i])
                begin
                    if (slot_countdown[i] == '0)
                    begin
                        // reload wraps to all ones when the period is zero
                        slot_countdown[i] = slot_period[i] - 16'd1;
                        fired.push_back(i[ptts_pkg::TASK_ID_W-1:0]);
                    end
                    else
                    begin
                        slot_countdown[i] = slot_countdown[i] - 16'd1;
                    end
                end
            end
            foreach (fired[j])
            begin
                entry.slot = fired[j];
                entry.last = (j == fired.size() - 1);
                due_q.push_back(entry);
            end
            due_total += fired.size();
        end
        else if (id < NUM_TASKS)
        begin
            case (kind)
                ptts_pkg::KIND_CREATE:
                begin
                    if (!slot_present[id])
                    begin
                        slot_present[id]   = 1'b1;
                        slot_ready[id]     = 1'b1;
                        slot_period[id]    = per;
                        slot_countdown[id] = fd;
                    end
                end
                ptts_pkg::KIND_SUSPEND: slot_ready[id]   = 1'b0;
                ptts_pkg::KIND_RESUME:  slot_ready[id]   = 1'b1;
                ptts_pkg::KIND_DELETE:  slot_present[id] = 1'b0;
                default: ;
            endcase
        end
    endfunction

    // Offer one command, hold it until the transfer, then update the model.
    task automatic issue_command(input logic [2:0] kind,
                                 input logic [ptts_pkg::TASK_ID_W-1:0] id,
                                 input logic [ptts_pkg::TIME_W-1:0] per,
                                 input logic [ptts_pkg::TIME_W-1:0] fd);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.kind        <= kind;
        cmd_ch.task_id     <= id;
        cmd_ch.period      <= per;
        cmd_ch.first_delay <= fd;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        apply_command(kind, id, per, fd);
    endtask

    always @(negedge clk)
    begin
        run_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin : check_run
        due_task_t want;
        if (rst_n && run_ch.valid && run_ch.ready)
        begin
            if (due_q.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected due task %0d last %0b",
                                        run_ch.run_task, run_ch.last));
            end
            else
            begin
                want = due_q.pop_front();
                if (run_ch.run_task !== want.slot || run_ch.last !== want.last)
                begin
                    flag_mismatch($sformatf("due task exp %0d last %0b, got %0d last %0b",
                                            want.slot, want.last,
                                            run_ch.run_task, run_ch.last));
                end
            end
        end
    end

    // End the run when nothing has been transferred for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (run_ch.valid && run_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("periodic_task_tick_scheduler_top: mismatch");
        $finish;
    end

    task automatic test_directed_commands;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        issue_command(ptts_pkg::KIND_TICK,    3'd0, 16'h0000, 16'h0000); // empty table
        issue_command(ptts_pkg::KIND_CREATE,  3'd0, 16'h0000, 16'h0000); // zero period
        issue_command(ptts_pkg::KIND_CREATE,  3'd7, 16'hFFFF, 16'hFFFF);
        issue_command(ptts_pkg::KIND_CREATE,  3'd3, 16'h0001, 16'h0000);
        issue_command(ptts_pkg::KIND_CREATE,  3'd0, 16'h0005, 16'h0002); // occupied: drop
        issue_command(ptts_pkg::KIND_TICK,    3'd0, 16'h0000, 16'h0000);
        issue_command(ptts_pkg::KIND_TICK,    3'd5, 16'hFFFF, 16'hFFFF);
        issue_command(ptts_pkg::KIND_SUSPEND, 3'd3, 16'h0000, 16'h0000);
        issue_command(ptts_pkg::KIND_TICK,    3'd0, 16'h0000, 16'h0000);
        issue_command(ptts_pkg::KIND_RESUME,  3'd3, 16'h0000, 16'h0000);
        issue_command(ptts_pkg::KIND_TICK,    3'd0, 16'h0000, 16'h0000);
        issue_command(ptts_pkg::KIND_SUSPEND, 3'd5, 16'h0000, 16'h0000); // empty slot
        issue_command(ptts_pkg::KIND_RESUME,  3'd6, 16'h0000, 16'h0000); // empty slot
        issue_command(ptts_pkg::KIND_DELETE,  3'd3, 16'h0000, 16'h0000);
        issue_command(ptts_pkg::KIND_TICK,    3'd0, 16'h0000, 16'h0000);
        issue_command(KIND_UNUSED_FIRST, 3'd2, 16'hAAAA, 16'h5555);
        issue_command(KIND_UNUSED_LAST,  3'd7, 16'hFFFF, 16'hFFFF);
    endtask

    // Fill every slot with an immediate task so one tick yields the full burst.
    task automatic test_all_slots_due;
        src_idle_pct   = 0;
        sink_stall_pct = 72;
        issue_command(ptts_pkg::KIND_DELETE, 3'd0, 16'h0000, 16'h0000);
        issue_command(ptts_pkg::KIND_DELETE, 3'd7, 16'h0000, 16'h0000);
        for (int i = 0; i < NUM_TASKS; i++)
            issue_command(ptts_pkg::KIND_CREATE, i[ptts_pkg::TASK_ID_W-1:0],
                          i[ptts_pkg::TIME_W-1:0], 16'h0000);
        issue_command(ptts_pkg::KIND_TICK, 3'd0, 16'h0000, 16'h0000);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int item_goal);
        int                             items;
        int                             pick;
        logic [2:0]                     kind;
        logic [ptts_pkg::TASK_ID_W-1:0] id;
        logic [ptts_pkg::TIME_W-1:0]    per;
        logic [ptts_pkg::TIME_W-1:0]    fd;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        items          = 0;
        while (items < item_goal)
        begin
            pick = $urandom_range(99);
            id   = ptts_pkg::TASK_ID_W'($urandom_range((1 << ptts_pkg::TASK_ID_W) - 1));
            // short periods and delays keep tasks firing; now and then go full range
            per  = ptts_pkg::TIME_W'(($urandom_range(7) == 0) ? $urandom_range(16'hFFFF)
                                                               : $urandom_range(6));
            fd   = ptts_pkg::TIME_W'(($urandom_range(7) == 0) ? $urandom_range(16'hFFFF)
                                                               : $urandom_range(4));
            if (pick < 45)
                kind = ptts_pkg::KIND_TICK;
            else if (pick < 67)
                kind = ptts_pkg::KIND_CREATE;
            else if (pick < 76)
                kind = ptts_pkg::KIND_SUSPEND;
            else if (pick < 85)
                kind = ptts_pkg::KIND_RESUME;
            else if (pick < 95)
                kind = ptts_pkg::KIND_DELETE;
            else
                kind = 3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
            issue_command(kind, id, per, fd);
            if (kind <= ptts_pkg::KIND_DELETE)
                items++;
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.kind        = ptts_pkg::KIND_TICK;
        cmd_ch.task_id     = '0;
        cmd_ch.period      = '0;
        cmd_ch.first_delay = '0;
        run_ch.ready       = 1'b0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        due_total          = 0;
        mismatch_count     = 0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            slot_present[i]   = 1'b0;
            slot_ready[i]     = 1'b0;
            slot_period[i]    = '0;
            slot_countdown[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_commands();
        test_all_slots_due();
        test_random_traffic(0,  0,  20);
        test_random_traffic(72, 0,  20);
        test_random_traffic(0,  72, 20);
        test_random_traffic(28, 28, 20);

        @(negedge clk);
        cmd_ch.valid   <= 1'b0;
        sink_stall_pct = 0;
        while (due_q.size() != 0)
            @(posedge clk);
        // catch any stray transfer after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && due_q.size() == 0)
            $display("periodic_task_tick_scheduler_top: match");
        else
            $display("periodic_task_tick_scheduler_top: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ptts_pkg.sv
hdl/ptts_if.sv
hdl/ptts_slot_ram.sv
hdl/periodic_task_tick_scheduler_top.sv
tb/sv/periodic_task_tick_scheduler_top_tb.sv
